>>> sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: periodic timer table shared definitions
// Table geometry, transaction codes, entry and result types.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int DEPTH  = 64;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_ADD    = 3'd1;
    localparam logic [2:0] KIND_PAUSE  = 3'd2;
    localparam logic [2:0] KIND_RESUME = 3'd3;
    localparam logic [2:0] KIND_DELETE = 3'd4;

    localparam logic [1:0] RK_FIRED = 2'd0;
    localparam logic [1:0] RK_ADDED = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;
    localparam logic [1:0] RK_ERROR = 2'd3;

    localparam logic [1:0] EC_NONE      = 2'd0;
    localparam logic [1:0] EC_INTERVAL  = 2'd1;
    localparam logic [1:0] EC_FULL      = 2'd2;
    localparam logic [1:0] EC_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    typedef struct packed {
        logic [30:0] interval;
        logic [31:0] last_fire;
        logic        is_shell;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  error_code;
        logic [15:0] timer_id;
        logic        fired_is_shell;
        logic        last;
    } t_result;

endpackage

>>> sv/ptt_if.sv
// ----------------------------------------------------------------------------
// ptt_if: request and result channels
// Valid/ready channels carrying one request or one result per transaction.
// ----------------------------------------------------------------------------
interface ptt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] now_seconds;
    logic [30:0] period_secs;
    logic        new_is_shell;
    logic [15:0] target_id;

    modport source (
        output valid, kind, now_seconds, period_secs, new_is_shell, target_id,
        input  ready
    );
    modport sink (
        input  valid, kind, now_seconds, period_secs, new_is_shell, target_id,
        output ready
    );
endinterface

interface ptt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [15:0] timer_id;
    logic        fired_is_shell;
    logic        last;

    modport source (
        output valid, result_kind, error_code, timer_id, fired_is_shell, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, error_code, timer_id, fired_is_shell, last,
        output ready
    );
endinterface

>>> sv/ptt_table.sv
// ----------------------------------------------------------------------------
// ptt_table: timer entry store
// One write port and one registered read port over the entry words.
// ----------------------------------------------------------------------------
module ptt_table (
    input  logic              i_clk,
    input  ptt_pkg::t_mem_req i_req,
    output ptt_pkg::t_entry   o_rd_data
);
    import ptt_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

>>> sv/ptt_due_unit.sv
// ----------------------------------------------------------------------------
// ptt_due_unit: expiry compare
// Modular age of one entry against its interval.
// ----------------------------------------------------------------------------
module ptt_due_unit (
    input  logic [31:0] i_now,
    input  logic [31:0] i_last_fire,
    input  logic [30:0] i_interval,
    input  logic        i_active,
    input  logic        i_paused,
    output logic        o_due
);
    import ptt_pkg::*;

    logic [31:0] age;

    assign age   = i_now - i_last_fire;
    assign o_due = i_active && !i_paused && (age >= {1'b0, i_interval});

endmodule

>>> sv/periodic_task_timer_table_top.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table_top: periodic timer table
// Add, pause, resume and delete timers; a tick scans the table and reports
// every timer that has expired, rearming it.
//
//   port   dir  modport  carries
//   i_in   in   sink     tick / add / pause / resume / delete request
//   o_out  out  source   fired / added / done / error result
//
// Add, pause, resume, delete: the sequencer registers the result, then loads
// it into the output register once that register is free. Tick: one entry
// per cycle, unless a stalled output holds the scan, through the entry store
// and the shared expiry compare, then a flush state hands on any last expiry.
// A stalled output holds the scan only when a further expiry must be passed on.
// Reset clears the slot count and all active flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_out_if.source o_out
);
    import ptt_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_slots_used, n_slots_used;
    logic [DEPTH-1:0]  r_active, n_active;
    logic [DEPTH-1:0]  r_paused, n_paused;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [31:0]       r_now, n_now;
    logic              r_pend_v, n_pend_v;
    logic [15:0]       r_pend_id, n_pend_id;
    logic              r_pend_shell, n_pend_shell;
    t_result           r_resp, n_resp;
    t_result           r_out, n_out;
    logic              r_out_v, n_out_v;

    t_mem_req          mem_req;
    t_entry            rd_data;
    logic              due;
    logic              out_free;
    logic              in_acc;
    logic [15:0]       tid_m1;
    logic [SLOT_W-1:0] tid_slot;
    logic [SLOT_W-1:0] add_slot;
    logic              tid_bad;
    logic [CNT_W-1:0]  idx_inc;
    logic              scan_last;

    ptt_table u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ptt_due_unit u_due (
        .i_now       (r_now),
        .i_last_fire (rd_data.last_fire),
        .i_interval  (rd_data.interval),
        .i_active    (r_active[r_idx]),
        .i_paused    (r_paused[r_idx]),
        .o_due       (due)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_v || o_out.ready;

    assign tid_m1    = i_in.target_id - 16'd1;
    assign tid_slot  = tid_m1[SLOT_W-1:0];
    assign add_slot  = r_slots_used[SLOT_W-1:0];
    assign tid_bad   = (i_in.target_id == 16'd0)
                    || (i_in.target_id > 16'(r_slots_used))
                    || !r_active[tid_slot];
    assign idx_inc   = CNT_W'(r_idx) + CNT_W'(1);
    assign scan_last = (idx_inc == r_slots_used);

    always_comb begin
        n_state      = r_state;
        n_slots_used = r_slots_used;
        n_active     = r_active;
        n_paused     = r_paused;
        n_idx        = r_idx;
        n_now        = r_now;
        n_pend_v     = r_pend_v;
        n_pend_id    = r_pend_id;
        n_pend_shell = r_pend_shell;
        n_resp       = r_resp;
        n_out        = r_out;
        n_out_v      = r_out_v && !o_out.ready;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_idx;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_idx;
        mem_req.wr_data = '{interval: rd_data.interval, last_fire: r_now,
                            is_shell: rd_data.is_shell};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        KIND_TICK: begin
                            n_now = i_in.now_seconds;
                            if (r_slots_used != '0) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                n_idx           = '0;
                                n_state         = S_SCAN;
                            end
                        end
                        KIND_ADD: begin
                            n_state = S_RESP;
                            if (i_in.period_secs == 31'd0) begin
                                n_resp = '{RK_ERROR, EC_INTERVAL, 16'd0, 1'b0, 1'b1};
                            end else if (r_slots_used >= CNT_W'(DEPTH)) begin
                                n_resp = '{RK_ERROR, EC_FULL, 16'd0, 1'b0, 1'b1};
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = add_slot;
                                mem_req.wr_data = '{interval: i_in.period_secs,
                                                    last_fire: i_in.now_seconds,
                                                    is_shell: i_in.new_is_shell};
                                n_active[add_slot] = 1'b1;
                                n_paused[add_slot] = 1'b0;
                                n_slots_used       = r_slots_used + CNT_W'(1);
                                n_resp = '{RK_ADDED, EC_NONE,
                                           16'(r_slots_used) + 16'd1,
                                           i_in.new_is_shell, 1'b1};
                            end
                        end
                        KIND_PAUSE, KIND_RESUME, KIND_DELETE: begin
                            n_state = S_RESP;
                            if (tid_bad) begin
                                n_resp = '{RK_ERROR, EC_NOT_FOUND, i_in.target_id,
                                           1'b0, 1'b1};
                            end else begin
                                if (i_in.kind == KIND_PAUSE) begin
                                    n_paused[tid_slot] = 1'b1;
                                end else if (i_in.kind == KIND_RESUME) begin
                                    n_paused[tid_slot] = 1'b0;
                                end else begin
                                    n_active[tid_slot] = 1'b0;
                                end
                                n_resp = '{RK_DONE, EC_NONE, i_in.target_id,
                                           1'b0, 1'b1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // hold the entry while an earlier expiry cannot be handed on
                if (!(due && r_pend_v && !out_free)) begin
                    if (due) begin
                        mem_req.wr_en = 1'b1;
                        n_pend_v      = 1'b1;
                        n_pend_id     = 16'(r_idx) + 16'd1;
                        n_pend_shell  = rd_data.is_shell;
                        if (r_pend_v) begin
                            n_out   = '{RK_FIRED, EC_NONE, r_pend_id, r_pend_shell, 1'b0};
                            n_out_v = 1'b1;
                        end
                    end
                    if (scan_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx           = r_idx + SLOT_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out    = '{RK_FIRED, EC_NONE, r_pend_id, r_pend_shell, 1'b1};
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out   = r_resp;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slots_used <= '0;
            r_active     <= '0;
            r_idx        <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slots_used <= n_slots_used;
            r_active     <= n_active;
            r_idx        <= n_idx;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paused     <= n_paused;
        r_now        <= n_now;
        r_pend_id    <= n_pend_id;
        r_pend_shell <= n_pend_shell;
        r_resp       <= n_resp;
        r_out        <= n_out;
    end

    assign o_out.valid          = r_out_v;
    assign o_out.result_kind    = r_out.result_kind;
    assign o_out.error_code     = r_out.error_code;
    assign o_out.timer_id       = r_out.timer_id;
    assign o_out.fired_is_shell = r_out.fired_is_shell;
    assign o_out.last           = r_out.last;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: periodic timer table
// Directed and random tick, add, pause, resume and delete transactions are
// tracked against a shadow copy of the timer table; every result transaction
// is compared in order, with random idling on both channels and one long
// result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import ptt_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 200;
    localparam int unsigned HOLD_AT       = 60;
    localparam int unsigned CALM_FROM     = 160;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 100;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_seconds;
        logic [30:0] period_secs;
        logic        new_is_shell;
        logic [15:0] target_id;
    } t_request;

    class timer_table_tracker;
        int unsigned slots_used;
        logic [30:0] interval_tab [DEPTH];
        logic [31:0] fired_at_tab [DEPTH];
        logic        shell_tab    [DEPTH];
        logic        paused_tab   [DEPTH];
        logic        active_tab   [DEPTH];
        t_result     pending_results [$];
        int unsigned failures;

        function new();
            slots_used = 0;
            failures   = 0;
            foreach (active_tab[i]) active_tab[i] = 1'b0;
        endfunction

        function t_result pack_result(logic [1:0] rk, logic [1:0] ec, logic [15:0] id,
                                      logic sh, logic lst);
            t_result r;
            r.result_kind    = rk;
            r.error_code     = ec;
            r.timer_id       = id;
            r.fired_is_shell = sh;
            r.last           = lst;
            return r;
        endfunction

        function void note_request(t_request rq);
            t_result     fired [$];
            int unsigned s;
            bit          found;
            case (rq.kind)
                KIND_TICK: begin
                    for (int i = 0; i < slots_used; i++) begin
                        if (active_tab[i] && !paused_tab[i] &&
                            (rq.now_seconds - fired_at_tab[i]) >= {1'b0, interval_tab[i]}) begin
                            fired_at_tab[i] = rq.now_seconds;
                            fired.push_back(pack_result(RK_FIRED, EC_NONE, 16'(i + 1),
                                                        shell_tab[i], 1'b0));
                        end
                    end
                    if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
                    foreach (fired[k]) pending_results.push_back(fired[k]);
                end
                KIND_ADD: begin
                    if (rq.period_secs == '0) begin
                        pending_results.push_back(pack_result(RK_ERROR, EC_INTERVAL, '0,
                                                              1'b0, 1'b1));
                    end else if (slots_used >= DEPTH) begin
                        pending_results.push_back(pack_result(RK_ERROR, EC_FULL, '0,
                                                              1'b0, 1'b1));
                    end else begin
                        s = slots_used;
                        interval_tab[s] = rq.period_secs;
                        fired_at_tab[s] = rq.now_seconds;
                        shell_tab[s]    = rq.new_is_shell;
                        paused_tab[s]   = 1'b0;
                        active_tab[s]   = 1'b1;
                        slots_used      = s + 1;
                        pending_results.push_back(pack_result(RK_ADDED, EC_NONE, 16'(s + 1),
                                                              rq.new_is_shell, 1'b1));
                    end
                end
                KIND_PAUSE, KIND_RESUME, KIND_DELETE: begin
                    found = (rq.target_id != '0) && (rq.target_id <= slots_used);
                    if (found) begin
                        s = rq.target_id - 1;
                        found = active_tab[s];
                    end
                    if (!found) begin
                        pending_results.push_back(pack_result(RK_ERROR, EC_NOT_FOUND,
                                                              rq.target_id, 1'b0, 1'b1));
                    end else begin
                        case (rq.kind)
                            KIND_PAUSE:  paused_tab[s] = 1'b1;
                            KIND_RESUME: paused_tab[s] = 1'b0;
                            default:     active_tab[s] = 1'b0;
                        endcase
                        pending_results.push_back(pack_result(RK_DONE, EC_NONE,
                                                              rq.target_id, 1'b0, 1'b1));
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_kind %0d timer_id %0d",
                       got.result_kind, got.timer_id);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
                failures++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code expected %0d actual %0d", want.error_code, got.error_code);
                failures++;
            end
            if (got.timer_id !== want.timer_id) begin
                $error("timer_id expected %0d actual %0d", want.timer_id, got.timer_id);
                failures++;
            end
            if (got.fired_is_shell !== want.fired_is_shell) begin
                $error("fired_is_shell expected %0d actual %0d",
                       want.fired_is_shell, got.fired_is_shell);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ptt_in_if  in_ch ();
    ptt_out_if out_ch ();

    periodic_task_timer_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    timer_table_tracker tracker;
    bit                 calm = 1'b0;
    bit                 hold_off_request = 1'b0;
    bit                 hold_off_done = 1'b0;
    int unsigned        cycle_count = 0;
    logic [31:0]        sim_seconds;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result({out_ch.result_kind, out_ch.error_code, out_ch.timer_id,
                                  out_ch.fired_is_shell, out_ch.last});
    end

    initial begin : result_sink
        int unsigned span;
        forever begin
            if (hold_off_request && !hold_off_done) begin
                out_ch.ready  <= 1'b0;
                span          = HOLD_CYCLES;
                hold_off_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                span         = $urandom_range(1, 15);
            end else begin
                out_ch.ready <= 1'b1;
                span         = calm ? 1 : $urandom_range(1, 20);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    task automatic send_request(input logic [2:0] kind, input logic [31:0] now_s,
                                input logic [30:0] ivl, input logic shell,
                                input logic [15:0] tid);
        t_request rq;
        rq.kind         = kind;
        rq.now_seconds  = now_s;
        rq.period_secs  = ivl;
        rq.new_is_shell = shell;
        rq.target_id    = tid;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.now_seconds  <= now_s;
        in_ch.period_secs  <= ivl;
        in_ch.new_is_shell <= shell;
        in_ch.target_id    <= tid;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.note_request(rq);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        logic [2:0]  kind;
        logic [30:0] ivl;
        logic        shell;
        logic [15:0] tid;
        int unsigned counted;
        int unsigned pick;

        tracker = new();
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_TICK;
        in_ch.now_seconds  <= '0;
        in_ch.period_secs  <= '0;
        in_ch.new_is_shell <= 1'b0;
        in_ch.target_id    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, bad interval, extreme intervals, wrap of the age
        send_request(KIND_TICK,   32'd0,         31'd0,          1'b0, 16'd0);
        send_request(KIND_ADD,    32'd100,       31'd0,          1'b1, 16'hFFFF);
        send_request(KIND_ADD,    32'hFFFF_FFF0, 31'd1,          1'b1, 16'd0);
        send_request(KIND_ADD,    32'hFFFF_FFF0, 31'h7FFF_FFFF,  1'b0, 16'd0);
        send_request(KIND_ADD,    32'hFFFF_FFF0, 31'd5,          1'b0, 16'd0);
        send_request(KIND_TICK,   32'hFFFF_FFF0, 31'd0,          1'b0, 16'd0);
        send_request(KIND_TICK,   32'hFFFF_FFF1, 31'd0,          1'b0, 16'd0);
        send_request(KIND_TICK,   32'h0000_0002, 31'd0,          1'b0, 16'd0);
        send_request(KIND_PAUSE,  32'd0,         31'd0,          1'b0, 16'd1);
        send_request(KIND_PAUSE,  32'd0,         31'd0,          1'b0, 16'd1);
        send_request(KIND_TICK,   32'h0000_0010, 31'd0,          1'b0, 16'd0);
        send_request(KIND_RESUME, 32'd0,         31'd0,          1'b0, 16'd3);
        send_request(KIND_RESUME, 32'd0,         31'd0,          1'b0, 16'd1);
        send_request(KIND_DELETE, 32'd0,         31'd0,          1'b0, 16'd2);
        send_request(KIND_DELETE, 32'd0,         31'd0,          1'b0, 16'd2);
        send_request(KIND_PAUSE,  32'd0,         31'd0,          1'b0, 16'd0);
        send_request(KIND_RESUME, 32'd0,         31'd0,          1'b0, 16'd4);
        send_request(KIND_DELETE, 32'd0,         31'd0,          1'b0, 16'hFFFF);
        send_request(KIND_SPARE_FIRST, $urandom, 31'($urandom), 1'b1, 16'($urandom));
        send_request(KIND_SPARE_MID,   $urandom, 31'($urandom), 1'b0, 16'($urandom));
        send_request(KIND_SPARE_LAST,  $urandom, 31'($urandom), 1'b1, 16'($urandom));
        send_request(KIND_TICK,   32'hFFFF_FFFF, 31'd0,          1'b0, 16'd0);
        send_request(KIND_ADD,    32'hFFFF_FFFF, 31'h7FFF_FFFF,  1'b1, 16'd0);

        counted     = 0;
        sim_seconds = 32'hFFFF_FF00;
        while (counted < RANDOM_ITEMS) begin
            if (counted == HOLD_AT) hold_off_request = 1'b1;
            if (counted == CALM_FROM) calm = 1'b1;
            pick  = $urandom_range(0, 99);
            shell = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0:       ivl = '0;
                1, 2:    ivl = 31'($urandom);
                3:       ivl = 31'($urandom_range(13, 200));
                default: ivl = 31'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 19))
                0, 1:    tid = 16'($urandom_range(0, 70));
                2:       tid = 16'($urandom);
                default: tid = 16'($urandom_range(0, tracker.slots_used + 1));
            endcase
            if (pick < 35) begin
                kind = KIND_TICK;
                case ($urandom_range(0, 19))
                    0, 1:    sim_seconds = $urandom;
                    2:       sim_seconds = 32'hFFFF_FFFF - $urandom_range(0, 10);
                    default: sim_seconds = sim_seconds + $urandom_range(0, 6);
                endcase
            end else if (pick < 75) begin
                kind = KIND_ADD;
            end else if (pick < 82) begin
                kind = KIND_PAUSE;
            end else if (pick < 88) begin
                kind = KIND_RESUME;
            end else if (pick < 95) begin
                kind = KIND_DELETE;
            end else begin
                kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            end
            if (kind <= KIND_DELETE) counted++;
            send_request(kind, (kind > KIND_DELETE) ? $urandom : sim_seconds, ivl, shell, tid);
        end

        in_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> periodic_task_timer_table_top.f
sv/ptt_pkg.sv
sv/ptt_if.sv
sv/ptt_table.sv
sv/ptt_due_unit.sv
sv/periodic_task_timer_table_top.sv
verif/testbench.sv
